// ===== rtl/sws_pkg.sv =====
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the sliding-window sender with fast
// retransmit: action and result codes, sequencer states, result slots.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  // Default configuration of the window and the sequence space
  localparam int DefWindow  = 8;
  localparam int DefSeqBits = 16;

  // Fixed field widths of the stream payloads
  localparam int PayloadW = 64;
  localparam int SeqOutW  = 16;
  localparam int AckW     = 16;
  localparam int ThrW     = 3;
  localparam int InDataW  = 104;  // 97 bits of fields, padded to whole bytes
  localparam int OutDataW = 88;   // 81 bits of fields, padded to whole bytes

  localparam logic [ThrW-1:0] DupThrReset = 3'd3;
  localparam logic [2:0]      DupCountMax = 3'd7;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_ACK     = 2'd1,
    ACT_TIMEOUT = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_SENT     = 3'd0,
    KIND_RESENT   = 3'd1,
    KIND_TSTART   = 3'd2,
    KIND_TSTOP    = 3'd3,
    KIND_REFUSED  = 3'd4,
    KIND_ABSORBED = 3'd5
  } kind_e;

  // Where the payload of a result comes from
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_INPUT = 2'd1,
    SRC_MEM   = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_MOD  = 2'd2,
    ST_EMIT = 2'd3
  } state_e;

  // One pending result of the current item
  typedef struct packed {
    kind_e              kind;
    logic [SeqOutW-1:0] seq;
    src_e               src;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/sws_ram.sv =====
// ----------------------------------------------------------------------------
// sws_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sliding_window_sender_fast_retransmit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_sender_fast_retransmit
// Sender side of a go-back-N transfer with fast retransmit: window slots of
// payload in RAM, base/next sequence tracking, duplicate-ack counting.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (low bit first)
//  s_axis    in   tuser: action; tdata: payload, ack_number, ack_checksum_ok,
//                 timer_seq
//  m_axis    out  tuser: kind; tdata: seq, payload_out, window_full;
//                 tlast: last
//  cfg       in   data: dup_threshold
//
//  An item yields n = 1..3 results: the sequencer takes the transfer,
//  evaluates and updates the window state, then emits the results in turn.
//  A resend with a window that is not a power of two adds a modulo step:
//  first the reciprocal multiply of the base, then its remainder and the
//  slot read.
//  Reset clears control state only; the payload RAM is not cleared.
//  A stall on m_axis holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_sender_fast_retransmit #(
  parameter int WINDOW   = sws_pkg::DefWindow,
  parameter int SEQ_BITS = sws_pkg::DefSeqBits
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // action
  input  wire logic [1:0]                   s_axis_tuser,
  // payload, ack_number, ack_checksum_ok, timer_seq
  input  wire logic [sws_pkg::InDataW-1:0]  s_axis_tdata,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // kind
  output logic [2:0]                        m_axis_tuser,
  // seq, payload_out, window_full
  output logic [sws_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // dup_threshold
  input  wire logic [sws_pkg::ThrW-1:0]     cfg_data_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o
);

  import sws_pkg::*;

  localparam int  SlotW   = $clog2(WINDOW);
  localparam bit  WinPow2 = ((WINDOW & (WINDOW - 1)) == 0);
  localparam int  RecipSh = SEQ_BITS + SlotW;
  // ceil(2^RecipSh / WINDOW): exact quotient for every SEQ_BITS-bit base
  localparam logic [SEQ_BITS:0] Recip = (SEQ_BITS + 1)'(
    ((64'd1 << RecipSh) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  typedef logic [SEQ_BITS-1:0] seq_t;

  // Window full: WINDOW <= d < half range
  function automatic logic win_full(seq_t d);
    win_full = !d[SEQ_BITS-1] && (32'(d) >= 32'(WINDOW));
  endfunction

  function automatic logic [SeqOutW-1:0] seq_out(seq_t s);
    logic [31:0] w;
    w = 32'(s);
    seq_out = w[SeqOutW-1:0];
  endfunction

  function automatic seq_t seq_in(logic [AckW-1:0] v);
    logic [31:0] w;
    w = {16'b0, v};
    seq_in = w[SEQ_BITS-1:0];
  endfunction

  function automatic logic [SlotW-1:0] slot_of(seq_t s);
    logic [31:0] w;
    w = 32'(s);
    slot_of = w[SlotW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [ThrW-1:0]  thr_q;
  seq_t             base_q, base_d;
  seq_t             next_q, next_d;
  logic             waiting_q, waiting_d;
  seq_t             las_q, las_d;
  logic             lav_q, lav_d;
  logic [2:0]       dc_q, dc_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;

  action_e          act_q;
  logic [PayloadW-1:0] pay_q;
  logic [AckW-1:0]  ack_q;
  logic             ok_q;
  logic [AckW-1:0]  tseq_q;

  res_t             res_q [3];
  res_t             res_d [3];
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       idx_q;

  seq_t             mod_src_q;
  seq_t             quo_q;
  logic             mod_cnt_q;

  logic             out_valid_q;
  kind_e            out_kind_q;
  logic [SeqOutW-1:0]  out_seq_q;
  logic [PayloadW-1:0] out_pl_q;
  logic             out_full_q;
  logic             out_last_q;

  logic             need_read;
  logic             wr_en;
  logic             rd_en;
  logic [SlotW-1:0] rd_addr;
  logic [PayloadW-1:0] rd_data;
  logic             in_xfer;
  logic             out_load;
  logic             emit_last;
  logic             mod_done;
  logic [2*SEQ_BITS:0] quo_prod;
  logic [SlotW-1:0] rem_slot;
  logic [PayloadW-1:0] res_pl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Evaluate the latched item against the window state
  // --------------------------------------------------------------------------
  always_comb begin
    logic [1:0] n;
    seq_t       ack_s;
    seq_t       ack_gap;
    seq_t       dout;
    seq_t       nxt1;
    logic [2:0] dc_inc;

    n           = 2'd0;
    ack_s       = seq_in(ack_q);
    ack_gap     = ack_s - base_q;
    nxt1        = next_q + seq_t'(1);
    dout        = '0;
    dc_inc      = (dc_q == DupCountMax) ? dc_q : dc_q + 3'd1;
    base_d      = base_q;
    next_d      = next_q;
    waiting_d   = waiting_q;
    las_d       = las_q;
    lav_d       = lav_q;
    dc_d        = dc_q;
    next_slot_d = next_slot_q;
    need_read   = 1'b0;
    wr_en       = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res_d[i] = '{kind: KIND_ABSORBED, seq: '0, src: SRC_NONE};
    end

    case (act_q)
      ACT_SEND: begin
        if (win_full(next_q - base_q)) begin
          waiting_d = 1'b1;
          res_d[n]  = '{kind: KIND_REFUSED, seq: seq_out(next_q), src: SRC_NONE};
          n         = n + 2'd1;
        end else begin
          wr_en = 1'b1;
          if (base_q == next_q) begin
            res_d[n] = '{kind: KIND_TSTART, seq: seq_out(next_q), src: SRC_NONE};
            n        = n + 2'd1;
          end
          res_d[n]  = '{kind: KIND_SENT, seq: seq_out(next_q), src: SRC_INPUT};
          n         = n + 2'd1;
          next_d    = nxt1;
          waiting_d = win_full(nxt1 - base_q);
          // Track next_seq mod WINDOW, restarting at zero on sequence wrap
          if (next_q == '1 || next_slot_q == SlotW'(WINDOW - 1)) begin
            next_slot_d = '0;
          end else begin
            next_slot_d = next_slot_q + SlotW'(1);
          end
        end
      end
      ACT_ACK: begin
        if (ok_q) begin
          if (lav_q && ack_s == las_q) begin
            if (dc_inc >= thr_q) begin
              res_d[n]  = '{kind: KIND_RESENT, seq: seq_out(base_q), src: SRC_MEM};
              n         = n + 2'd1;
              need_read = 1'b1;
              dc_d      = '0;
            end else begin
              dc_d = dc_inc;
            end
          end else begin
            las_d = ack_s;
            lav_d = 1'b1;
            dc_d  = '0;
          end
          // Cumulative ack at or ahead of the base: move the base past it
          if (!ack_gap[SEQ_BITS-1]) begin
            res_d[n]  = '{kind: KIND_TSTOP, seq: seq_out(base_q), src: SRC_NONE};
            n         = n + 2'd1;
            base_d    = ack_s + seq_t'(1);
            dout      = next_q - base_d;
            if (dout != '0 && !dout[SEQ_BITS-1]) begin
              res_d[n] = '{kind: KIND_TSTART, seq: seq_out(base_d), src: SRC_NONE};
              n        = n + 2'd1;
            end
            waiting_d = win_full(dout);
          end
        end
        if (n == 2'd0) begin
          res_d[0] = '{kind: KIND_ABSORBED, seq: ack_q, src: SRC_NONE};
          n        = 2'd1;
        end
      end
      ACT_TIMEOUT: begin
        res_d[0]  = '{kind: KIND_TSTOP, seq: seq_out(seq_in(tseq_q)), src: SRC_NONE};
        res_d[1]  = '{kind: KIND_RESENT, seq: seq_out(base_q), src: SRC_MEM};
        res_d[2]  = '{kind: KIND_TSTART, seq: seq_out(base_q), src: SRC_NONE};
        n         = 2'd3;
        need_read = 1'b1;
      end
      default: begin
        res_d[0] = '{kind: KIND_ABSORBED, seq: '0, src: SRC_NONE};
        n        = 2'd1;
      end
    endcase
    cnt_d = n;
  end

  // --------------------------------------------------------------------------
  // Remainder of the base by a window that is not a power of two:
  // reciprocal multiply registered as the quotient, multiply back and subtract in the next
  // --------------------------------------------------------------------------
  assign quo_prod = (2 * SEQ_BITS + 1)'(mod_src_q) * (2 * SEQ_BITS + 1)'(Recip);
  assign rem_slot = SlotW'(mod_src_q - seq_t'(quo_q * seq_t'(WINDOW)));
  assign mod_done = mod_cnt_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (need_read && !WinPow2) begin
          state_d = ST_MOD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs: RAM port control and result emission
  // --------------------------------------------------------------------------
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = WinPow2 ? slot_of(base_q) : rem_slot;
    out_load = 1'b0;
    case (state_q)
      ST_EVAL: rd_en = need_read && WinPow2;
      ST_MOD:  rd_en = mod_done;
      ST_EMIT: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign emit_last = (idx_q == cnt_q - 2'd1);

  always_comb begin
    case (res_q[idx_q].src)
      SRC_INPUT: res_pl = pay_q;
      SRC_MEM:   res_pl = rd_data;
      default:   res_pl = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Payload slots
  // --------------------------------------------------------------------------
  sws_ram #(
    .WIDTH (PayloadW),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en && state_q == ST_EVAL),
    .wr_addr_i (next_slot_q),
    .wr_data_i (pay_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= DupThrReset;
      base_q      <= '0;
      next_q      <= '0;
      waiting_q   <= 1'b0;
      las_q       <= '0;
      lav_q       <= 1'b0;
      dc_q        <= '0;
      next_slot_q <= '0;
      cnt_q       <= 2'd1;
      idx_q       <= '0;
      mod_cnt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      // Commit the window update
      if (state_q == ST_EVAL) begin
        base_q      <= base_d;
        next_q      <= next_d;
        waiting_q   <= waiting_d;
        las_q       <= las_d;
        lav_q       <= lav_d;
        dc_q        <= dc_d;
        next_slot_q <= next_slot_d;
        cnt_q       <= cnt_d;
        idx_q       <= '0;
        mod_cnt_q   <= 1'b0;
      end
      if (state_q == ST_MOD) begin
        mod_cnt_q <= 1'b1;
      end
      // Advance through the pending results
      if (out_load) begin
        idx_q <= idx_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q  <= action_e'(s_axis_tuser);
      pay_q  <= s_axis_tdata[63:0];
      ack_q  <= s_axis_tdata[79:64];
      ok_q   <= s_axis_tdata[80];
      tseq_q <= s_axis_tdata[96:81];
    end
    if (state_q == ST_EVAL) begin
      res_q     <= res_d;
      mod_src_q <= base_q;
    end
    if (state_q == ST_MOD) begin
      quo_q <= seq_t'(quo_prod >> RecipSh);
    end
    if (out_load) begin
      out_kind_q <= res_q[idx_q].kind;
      out_seq_q  <= res_q[idx_q].seq;
      out_pl_q   <= res_pl;
      out_full_q <= waiting_q;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'b0, out_full_q, out_pl_q, out_seq_q};

endmodule

`default_nettype wire
